// ----- src/gnmp_pkg.sv -----
// Package: shared types, constants and step tables for the gauge needle mask polygon block
`timescale 1ns / 1ps
package gnmp_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int TRIG_FRAC_DEF  = 15;
    localparam int ADDR_W         = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int COORD_CALC_W   = 18;

    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int OCTANT_UNITS = 2880;
    localparam int MIN_FILL     = 32;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // pi*2^30/11520 split into integer part and remainder over 11520
    localparam int X_INT_MUL = 292817;
    localparam int X_REM_MUL = 7586;
    // floor(n/45) = (n*DIV45_MUL)>>24 for n < 2^18
    localparam int DIV45_MUL = 372828;
    // floor(n/7) = (n*DIV7_MUL)>>15 for n < 2^12
    localparam int DIV7_MUL  = 4682;

    typedef enum logic [2:0] {
        REG_MIN_VALUE   = 3'd0,
        REG_MAX_VALUE   = 3'd1,
        REG_START_ANGLE = 3'd2,
        REG_SWEEP_ANGLE = 3'd3,
        REG_BOX_X       = 3'd4,
        REG_BOX_Y       = 3'd5,
        REG_BOX_SIZE    = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        C_LEFT_MID  = 3'd0,
        C_TOP_LEFT  = 3'd1,
        C_TOP_MID   = 3'd2,
        C_TOP_RIGHT = 3'd3,
        C_RIGHT_MID = 3'd4,
        C_BOT_RIGHT = 3'd5
    } corner_t;

    typedef enum logic [1:0] {
        QD_0 = 2'd0,
        QD_1 = 2'd1,
        QD_2 = 2'd2,
        QD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic signed [15:0] start_angle;
        logic signed [15:0] sweep_angle;
        logic [11:0]        box_x;
        logic [11:0]        box_y;
        logic [11:0]        box_size;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] fill;
        corner_t            start;
        logic               err;
    } q_entry_t;

    // Taylor divisors and floor(2^32/k) for each Horner step
    function automatic logic [7:0] sin_k(input logic [2:0] step);
        logic [7:0] k;
        unique case (step)
            3'd0:    k = 8'd110;
            3'd1:    k = 8'd72;
            3'd2:    k = 8'd42;
            3'd3:    k = 8'd20;
            default: k = 8'd6;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] sin_m(input logic [2:0] step);
        logic [31:0] m;
        unique case (step)
            3'd0:    m = 32'd39045157;
            3'd1:    m = 32'd59652323;
            3'd2:    m = 32'd102261126;
            3'd3:    m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] cos_k(input logic [2:0] step);
        logic [7:0] k;
        unique case (step)
            3'd0:    k = 8'd132;
            3'd1:    k = 8'd90;
            3'd2:    k = 8'd56;
            3'd3:    k = 8'd30;
            3'd4:    k = 8'd12;
            default: k = 8'd2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] cos_m(input logic [2:0] step);
        logic [31:0] m;
        unique case (step)
            3'd0:    m = 32'd32537631;
            3'd1:    m = 32'd47721858;
            3'd2:    m = 32'd76695844;
            3'd3:    m = 32'd143165576;
            3'd4:    m = 32'd357913941;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

// ----- src/gnmp_if.sv -----
// Interfaces: reading input channel and polygon point output channel
`timescale 1ns / 1ps
interface gnmp_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] reading;

    modport source (output valid, output reading, input ready);
    modport sink   (input valid, input reading, output ready);
endinterface

interface gnmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] point_x;
    logic signed [13:0] point_y;
    logic               last_point;
    logic signed [15:0] fill_angle;
    logic               octant_error;

    modport source (output valid, output point_x, output point_y, output last_point,
                    output fill_angle, output octant_error, input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    input fill_angle, input octant_error, output ready);
endinterface

// ----- src/gnmp_front.sv -----
// Front end: reading intake, scaled angle by iterative divide, octant classification
`timescale 1ns / 1ps
module gnmp_front import gnmp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    gnmp_in_if.sink  sample,
    output logic     push,
    output q_entry_t push_data,
    input  logic     full
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } div_state_t;

    div_state_t         dstate_reg, dstate_next;
    logic               s0_valid_reg, s0_valid_next;
    logic signed [32:0] prod_reg;
    logic signed [16:0] rng_reg;
    logic               s0_gtmax_reg, s0_gtmin_reg;

    logic [16:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic [15:0]        dv_reg;
    logic               neg_reg, zero_reg, gtmax_reg, gtmin_reg;
    logic [2:0]         cnt_reg;

    logic               accept, div_start;
    logic signed [16:0] diff_c, rng_c;
    logic signed [32:0] prod_c, prod_abs;
    logic signed [16:0] rng_abs;
    logic signed [15:0] quo16, angle_c, fill_c;
    corner_t            start_c;
    logic               err_c;

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = !s0_valid_reg || div_start;
    assign push         = (dstate_reg == D_DONE) && !full;
    assign div_start    = s0_valid_reg && ((dstate_reg == D_IDLE) || push);

    assign diff_c = 17'(sample.reading) - 17'(cfg.min_value);
    assign rng_c  = 17'(cfg.max_value) - 17'(cfg.min_value);
    assign prod_c = 33'(cfg.sweep_angle) * 33'(diff_c);

    assign prod_abs = prod_reg[32] ? -prod_reg : prod_reg;
    assign rng_abs  = rng_reg[16] ? -rng_reg : rng_reg;

    always_comb
    begin
        logic [16:0] r;
        logic [31:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 4; i++)
        begin
            r = {r[15:0], q[31]};
            q = {q[30:0], 1'b0};
            if (r >= {1'b0, dv_reg})
            begin
                r    = r - {1'b0, dv_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_comb
    begin
        logic signed [15:0] qm;
        qm    = $signed(quo_reg[15:0]);
        quo16 = zero_reg ? '0 : (neg_reg ? -qm : qm);
    end

    assign angle_c = cfg.start_angle + quo16;
    assign fill_c  = gtmax_reg ? cfg.sweep_angle : (gtmin_reg ? quo16 : 16'(MIN_FILL));

    always_comb
    begin
        err_c   = 1'b0;
        start_c = C_LEFT_MID;
        if (angle_c < -OCTANT_UNITS || angle_c >= 6 * OCTANT_UNITS)
            err_c = 1'b1;
        else if (angle_c < 0)
            start_c = C_BOT_RIGHT;
        else if (angle_c < OCTANT_UNITS)
            start_c = C_RIGHT_MID;
        else if (angle_c < 2 * OCTANT_UNITS)
            start_c = C_TOP_RIGHT;
        else if (angle_c < 3 * OCTANT_UNITS)
            start_c = C_TOP_MID;
        else if (angle_c < 4 * OCTANT_UNITS)
            start_c = C_TOP_LEFT;
        else
            start_c = C_LEFT_MID;
    end

    assign push_data.angle = angle_c;
    assign push_data.fill  = fill_c;
    assign push_data.start = start_c;
    assign push_data.err   = err_c;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (accept)
            s0_valid_next = 1'b1;
        else if (div_start)
            s0_valid_next = 1'b0;
    end

    always_comb
    begin
        dstate_next = dstate_reg;
        unique case (dstate_reg)
            D_IDLE: if (div_start) dstate_next = D_RUN;
            D_RUN:  if (cnt_reg == '1) dstate_next = D_DONE;
            D_DONE:
            begin
                if (div_start)
                    dstate_next = D_RUN;
                else if (push)
                    dstate_next = D_IDLE;
            end
            default: dstate_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg   <= D_IDLE;
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            dstate_reg   <= dstate_next;
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg     <= prod_c;
            rng_reg      <= rng_c;
            s0_gtmax_reg <= sample.reading > cfg.max_value;
            s0_gtmin_reg <= sample.reading > cfg.min_value;
        end
        if (div_start)
        begin
            rem_reg   <= '0;
            quo_reg   <= prod_abs[31:0];
            dv_reg    <= rng_abs[15:0];
            neg_reg   <= prod_reg[32] ^ rng_reg[16];
            zero_reg  <= (rng_reg == '0);
            gtmax_reg <= s0_gtmax_reg;
            gtmin_reg <= s0_gtmin_reg;
            cnt_reg   <= '0;
        end
        else if (dstate_reg == D_RUN)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (dstate_reg == D_RUN && cnt_reg == '1) |=> (dstate_reg == D_DONE))
        else $error("divider did not finish after its last step");

endmodule

// ----- src/gnmp_fifo.sv -----
// Short queue between the front end and the trig engine
`timescale 1ns / 1ps
module gnmp_fifo import gnmp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    output logic     pop_valid,
    output q_entry_t pop_data,
    input  logic     pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        mem [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem[rd_reg];
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            if (do_pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            if (push && !do_pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ----- src/gnmp_trig.sv -----
// Trig engine: quarter-turn reduction, Q30 Horner sine/cosine on one shared sequencer
`timescale 1ns / 1ps
module gnmp_trig import gnmp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  q_entry_t                      job,
    output logic                          job_ready,
    output logic                          res_valid,
    output q_entry_t                      res_job,
    output logic signed [TRIG_FRAC_BITS+1:0] res_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] res_cos,
    input  logic                          res_ready
);

    localparam int SW = TRIG_FRAC_BITS + 2;
    localparam int SH = 30 - TRIG_FRAC_BITS;

    typedef enum logic [10:0] {
        T_IDLE = 11'b000_0000_0001,
        T_X1   = 11'b000_0000_0010,
        T_X2   = 11'b000_0000_0100,
        T_X3   = 11'b000_0000_1000,
        T_SQ   = 11'b000_0001_0000,
        T_HMUL = 11'b000_0010_0000,
        T_HREC = 11'b000_0100_0000,
        T_HUPD = 11'b000_1000_0000,
        T_SFIN = 11'b001_0000_0000,
        T_RND  = 11'b010_0000_0000,
        T_DONE = 11'b100_0000_0000
    } trig_state_t;

    trig_state_t        state_reg, state_next;
    q_entry_t           job_reg;
    quad_t              quad_reg;
    logic [12:0]        r_reg;
    logic [31:0]        m1_reg;
    logic [25:0]        m2_reg;
    logic [36:0]        m3_reg;
    logic [30:0]        x_reg;
    logic [31:0]        x2_reg;
    logic [30:0]        ts_reg, tc_reg;
    logic [31:0]        vs_reg, vc_reg, qs_reg, qc_reg;
    logic [2:0]         k_reg;
    logic [30:0]        sraw_reg;
    logic signed [SW-1:0] sn_reg, cs_reg;

    quad_t              quad_c;
    logic [12:0]        r_c;
    logic [61:0]        sq_p, sf_p;
    logic [62:0]        vs_p, vc_p;
    logic [63:0]        qs_p, qc_p;
    logic [30:0]        ts_new, tc_new;
    logic [31:0]        rs_sum, rc_sum;
    logic [SW-1:0]      s_mag, c_mag;
    logic signed [SW-1:0] s_pos, c_pos;

    assign job_ready = (state_reg == T_IDLE);
    assign res_valid = (state_reg == T_DONE);
    assign res_job   = job_reg;
    assign res_sin   = sn_reg;
    assign res_cos   = cs_reg;

    always_comb
    begin
        logic signed [16:0] a;
        a = 17'(job.angle);
        if (a < 0)
            a = a + 17'(FULL_TURN);
        if (a < 0)
            a = a + 17'(FULL_TURN);
        if (a >= 17'(FULL_TURN))
            a = a - 17'(FULL_TURN);
        if (a >= 17'(3 * QUARTER_TURN))
        begin
            quad_c = QD_3;
            a      = a - 17'(3 * QUARTER_TURN);
        end
        else if (a >= 17'(2 * QUARTER_TURN))
        begin
            quad_c = QD_2;
            a      = a - 17'(2 * QUARTER_TURN);
        end
        else if (a >= 17'(QUARTER_TURN))
        begin
            quad_c = QD_1;
            a      = a - 17'(QUARTER_TURN);
        end
        else
            quad_c = QD_0;
        r_c = a[12:0];
    end

    assign sq_p = 62'(x_reg) * 62'(x_reg);
    assign vs_p = 63'(x2_reg) * 63'(ts_reg);
    assign vc_p = 63'(x2_reg) * 63'(tc_reg);
    assign qs_p = 64'(vs_reg) * 64'(sin_m(k_reg));
    assign qc_p = 64'(vc_reg) * 64'(cos_m(k_reg));
    assign sf_p = 62'(x_reg) * 62'(ts_reg);

    // one Horner update with the reciprocal quotient corrected by at most one
    function automatic logic [30:0] horner_upd(input logic [31:0] v, input logic [31:0] q0,
                                              input logic [7:0] k);
        logic [31:0] rem;
        logic [31:0] q;
        rem = v - 32'(q0 * 32'(k));
        q   = q0 + 32'(rem >= 32'(k));
        return (q >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - q);
    endfunction

    assign ts_new = horner_upd(vs_reg, qs_reg, sin_k(k_reg));
    assign tc_new = horner_upd(vc_reg, qc_reg, cos_k(k_reg));

    assign rs_sum = 32'(sraw_reg) + 32'(1 << (SH - 1));
    assign rc_sum = 32'(tc_reg) + 32'(1 << (SH - 1));
    assign s_mag  = rs_sum[31:SH];
    assign c_mag  = rc_sum[31:SH];
    assign s_pos  = $signed(s_mag);
    assign c_pos  = $signed(c_mag);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (job_valid) state_next = T_X1;
            T_X1:   state_next = T_X2;
            T_X2:   state_next = T_X3;
            T_X3:   state_next = T_SQ;
            T_SQ:   state_next = T_HMUL;
            T_HMUL: state_next = T_HREC;
            T_HREC: state_next = T_HUPD;
            T_HUPD: state_next = (k_reg == 3'd5) ? T_SFIN : T_HMUL;
            T_SFIN: state_next = T_RND;
            T_RND:  state_next = T_DONE;
            T_DONE: if (res_ready) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            T_IDLE:
            begin
                job_reg  <= job;
                quad_reg <= quad_c;
                r_reg    <= r_c;
            end
            T_X1:
            begin
                m1_reg <= 32'(r_reg) * 32'(X_INT_MUL);
                m2_reg <= 26'(r_reg) * 26'(X_REM_MUL);
            end
            T_X2: m3_reg <= 37'(m2_reg[25:8]) * 37'(DIV45_MUL);
            T_X3: x_reg  <= 31'(m1_reg + 32'(m3_reg[36:24]));
            T_SQ:
            begin
                x2_reg <= sq_p[61:30];
                ts_reg <= Q30_ONE;
                tc_reg <= Q30_ONE;
                k_reg  <= '0;
            end
            T_HMUL:
            begin
                vs_reg <= vs_p[61:30];
                vc_reg <= vc_p[61:30];
            end
            T_HREC:
            begin
                qs_reg <= qs_p[63:32];
                qc_reg <= qc_p[63:32];
            end
            T_HUPD:
            begin
                tc_reg <= tc_new;
                if (k_reg != 3'd5)
                    ts_reg <= ts_new;
                k_reg <= k_reg + 3'd1;
            end
            T_SFIN: sraw_reg <= sf_p[60:30];
            T_RND:
            begin
                unique case (quad_reg)
                    QD_0:
                    begin
                        sn_reg <= s_pos;
                        cs_reg <= c_pos;
                    end
                    QD_1:
                    begin
                        sn_reg <= c_pos;
                        cs_reg <= -s_pos;
                    end
                    QD_2:
                    begin
                        sn_reg <= -s_pos;
                        cs_reg <= -c_pos;
                    end
                    default:
                    begin
                        sn_reg <= -c_pos;
                        cs_reg <= s_pos;
                    end
                endcase
            end
            default: ;
        endcase
    end

endmodule

// ----- src/gnmp_emit.sv -----
// Point emitter: box geometry, needle tip, octant-selected corners into the output register
`timescale 1ns / 1ps
module gnmp_emit import gnmp_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cfg_t                             cfg,
    input  logic                             job_valid,
    input  q_entry_t                         job,
    input  logic signed [TRIG_FRAC_BITS+1:0] job_sin,
    input  logic signed [TRIG_FRAC_BITS+1:0] job_cos,
    output logic                             job_ready,
    gnmp_out_if.source                       point
);

    localparam int SW = TRIG_FRAC_BITS + 2;
    localparam int PW = 13 + SW;
    localparam int CW = COORD_CALC_W;

    typedef enum logic [3:0] {
        E_IDLE   = 4'b0001,
        E_CENTER = 4'b0010,
        E_TIP    = 4'b0100,
        E_EDGE   = 4'b1000
    } emit_state_t;

    emit_state_t          state_reg, state_next;
    q_entry_t             job_reg;
    logic signed [SW-1:0] sn_reg, cs_reg;
    corner_t              ci_reg;
    logic [13:0]          cx_reg, cy_reg;
    logic [11:0]          rad_reg;
    logic [10:0]          half_reg;
    logic signed [CW-1:0] dx_reg, dy_reg;
    logic                 ovalid_reg;
    logic [13:0]          ox_reg, oy_reg;
    logic                 olast_reg;
    logic signed [15:0]   ofill_reg;
    logic                 oerr_reg;

    logic                 adv, emit;
    logic [24:0]          p7;
    logic [7:0]           pad_c;
    logic [11:0]          side_c;
    logic [10:0]          hside_c;
    logic signed [CW-1:0] ex_c, ey_c;
    logic signed [CW-1:0] bx_c, by_c, bs_c, h_c;

    assign adv       = !ovalid_reg || point.ready;
    assign emit      = adv && (state_reg != E_IDLE);
    assign job_ready = (state_reg == E_IDLE);

    assign p7      = 25'(cfg.box_size) * 25'(DIV7_MUL);
    assign pad_c   = p7[24:17];
    assign side_c  = cfg.box_size - 12'({pad_c, 1'b0});
    assign hside_c = side_c[11:1];

    function automatic logic signed [CW-1:0] tip_off(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] a;
        a = p[PW-1] ? p + PW'((1 << TRIG_FRAC_BITS) - 1) : p;
        return CW'(a >>> TRIG_FRAC_BITS);
    endfunction

    function automatic logic [13:0] wrap(input logic signed [CW-1:0] v);
        logic signed [COORD_BITS:0] w;
        logic signed [CW-1:0]       e;
        w = v[COORD_BITS:0];
        e = CW'(w);
        return e[13:0];
    endfunction

    assign bx_c = $signed(CW'(cfg.box_x));
    assign by_c = $signed(CW'(cfg.box_y));
    assign bs_c = $signed(CW'(cfg.box_size));
    assign h_c  = $signed(CW'(half_reg));

    always_comb
    begin
        case (ci_reg)
            C_LEFT_MID:
            begin
                ex_c = bx_c;
                ey_c = by_c + h_c;
            end
            C_TOP_LEFT:
            begin
                ex_c = bx_c;
                ey_c = by_c;
            end
            C_TOP_MID:
            begin
                ex_c = bx_c + h_c;
                ey_c = by_c;
            end
            C_TOP_RIGHT:
            begin
                ex_c = bx_c + bs_c;
                ey_c = by_c;
            end
            C_RIGHT_MID:
            begin
                ex_c = bx_c + bs_c;
                ey_c = by_c + h_c;
            end
            default:
            begin
                ex_c = bx_c + bs_c;
                ey_c = by_c + bs_c;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:   if (job_valid) state_next = E_CENTER;
            E_CENTER: if (adv) state_next = E_TIP;
            E_TIP:    if (adv) state_next = job_reg.err ? E_IDLE : E_EDGE;
            E_EDGE:   if (adv && ci_reg == C_BOT_RIGHT) state_next = E_IDLE;
            default:  state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                ovalid_reg <= 1'b1;
            else if (point.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= 14'(cfg.box_x) + 14'(pad_c) + 14'(hside_c);
        cy_reg   <= 14'(cfg.box_y) + 14'(pad_c) + 14'(hside_c);
        rad_reg  <= 12'(hside_c) + 12'(pad_c);
        half_reg <= cfg.box_size[11:1];
        dx_reg   <= tip_off(PW'($signed({1'b0, rad_reg})) * PW'(cs_reg));
        dy_reg   <= tip_off(PW'($signed({1'b0, rad_reg})) * PW'(sn_reg));

        if (state_reg == E_IDLE && job_valid)
        begin
            job_reg <= job;
            sn_reg  <= job_sin;
            cs_reg  <= job_cos;
        end

        if (emit)
        begin
            ofill_reg <= job_reg.fill;
            oerr_reg  <= job_reg.err;
            unique case (state_reg)
                E_CENTER:
                begin
                    ox_reg    <= wrap(bx_c + h_c);
                    oy_reg    <= wrap(by_c + h_c);
                    olast_reg <= 1'b0;
                end
                E_TIP:
                begin
                    ox_reg    <= wrap($signed(CW'(cx_reg)) + dx_reg);
                    oy_reg    <= wrap($signed(CW'(cy_reg)) - dy_reg);
                    olast_reg <= job_reg.err;
                    ci_reg    <= job_reg.start;
                end
                default:
                begin
                    ox_reg    <= wrap(ex_c);
                    oy_reg    <= wrap(ey_c);
                    olast_reg <= (ci_reg == C_BOT_RIGHT);
                    ci_reg    <= corner_t'(ci_reg + 3'd1);
                end
            endcase
        end
    end

    assign point.valid        = ovalid_reg;
    assign point.point_x      = $signed(ox_reg);
    assign point.point_y      = $signed(oy_reg);
    assign point.last_point   = olast_reg;
    assign point.fill_angle   = ofill_reg;
    assign point.octant_error = oerr_reg;

    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_TIP && emit && job_reg.err) |=> (ovalid_reg && olast_reg))
        else $error("octant error polygon not closed after tip");

endmodule

// ----- src/gauge_needle_mask_polygon.sv -----
// Top level: configuration registers, front end, queue, trig engine and point emitter
//
//  channel   dir  handshake                         payload
//  APB       in   psel/penable/pwrite, pready=1     paddr, pwdata, prdata
//  sample    in   valid/ready                       reading
//  point     out  valid/ready                       point_x, point_y, last_point,
//                                                   fill_angle, octant_error
//
// Front end: registered multiply, iterative divide (4 quotient bits per cycle), then hand-off.
// Trig engine: angle scaling and squaring (X1, X2, X3, SQ), then the Horner sequencer
// (HMUL, HREC, HUPD per term, six terms, sine and cosine lanes side by side, the sine
// lane updating in the first five), then finish and round (SFIN, RND); one reading at a time.
// Emitter: 2 to 8 points per reading, one per cycle unless held; overlaps next trig job.
// Reset clears control state and loads config defaults; no clearing pass. Each side stalls on its own ready.
`timescale 1ns / 1ps
module gauge_needle_mask_polygon import gnmp_pkg::*;
#(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    gnmp_in_if.sink           sample,
    gnmp_out_if.source        point
);

    cfg_t                         cfg_reg;
    reg_idx_t                     idx;
    logic                         wr_en;
    logic                         push, full, q_valid, q_pop;
    q_entry_t                     push_data, q_data, t_job;
    logic                         t_valid, t_ready;
    logic signed [TRIG_FRAC_BITS+1:0] t_sin, t_cos;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value   <= 16'sd0;
            cfg_reg.max_value   <= 16'sd100;
            cfg_reg.start_angle <= -16'sd2880;
            cfg_reg.sweep_angle <= 16'sd17280;
            cfg_reg.box_x       <= 12'd0;
            cfg_reg.box_y       <= 12'd0;
            cfg_reg.box_size    <= 12'd140;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_VALUE:   cfg_reg.min_value   <= $signed(pwdata[15:0]);
                REG_MAX_VALUE:   cfg_reg.max_value   <= $signed(pwdata[15:0]);
                REG_START_ANGLE: cfg_reg.start_angle <= $signed(pwdata[15:0]);
                REG_SWEEP_ANGLE: cfg_reg.sweep_angle <= $signed(pwdata[15:0]);
                REG_BOX_X:       cfg_reg.box_x       <= pwdata[11:0];
                REG_BOX_Y:       cfg_reg.box_y       <= pwdata[11:0];
                REG_BOX_SIZE:    cfg_reg.box_size    <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN_VALUE:   prdata = {16'h0, cfg_reg.min_value};
            REG_MAX_VALUE:   prdata = {16'h0, cfg_reg.max_value};
            REG_START_ANGLE: prdata = {16'h0, cfg_reg.start_angle};
            REG_SWEEP_ANGLE: prdata = {16'h0, cfg_reg.sweep_angle};
            REG_BOX_X:       prdata = {20'h0, cfg_reg.box_x};
            REG_BOX_Y:       prdata = {20'h0, cfg_reg.box_y};
            REG_BOX_SIZE:    prdata = {20'h0, cfg_reg.box_size};
            default:         prdata = '0;
        endcase
    end

    gnmp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sample    (sample),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    gnmp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .pop       (q_pop)
    );

    gnmp_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_data),
        .job_ready (q_pop),
        .res_valid (t_valid),
        .res_job   (t_job),
        .res_sin   (t_sin),
        .res_cos   (t_cos),
        .res_ready (t_ready)
    );

    gnmp_emit #(.COORD_BITS(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (t_valid),
        .job       (t_job),
        .job_sin   (t_sin),
        .job_cos   (t_cos),
        .job_ready (t_ready),
        .point     (point)
    );

endmodule
